@@ rtl/core/trm_pkg.sv @@
// Package with the widths, constants and controller states of the traffic rate meter.
`default_nettype none

package trm_pkg;

  localparam int BYTE_COUNT_WIDTH = 40;
  localparam int PKT_ACC_W = 32;
  localparam int PKT_SUM_W = 40;
  localparam int CNT_W = 17;
  localparam int LIMIT_W = 16;
  localparam int OUT_BYTES_W = 40;
  localparam int OUT_PKTS_W = 32;

  localparam int SUM_W = (BYTE_COUNT_WIDTH + 8 > 64) ? 64 : BYTE_COUNT_WIDTH + 8;
  localparam int DIV_W = (SUM_W > PKT_SUM_W) ? SUM_W : PKT_SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam int LIMIT_RESET = 60;
  localparam int VALID_DIVISOR = 10;
  localparam int TENTH_W = $clog2(((1 << LIMIT_W) - 1) / VALID_DIVISOR + 1);
  localparam int TENTH_MUL_W = 17;
  localparam logic [TENTH_MUL_W-1:0] TENTH_MUL = 17'd52429;
  localparam int TENTH_SHIFT = 19;
  localparam int TENTH_PROD_W = LIMIT_W + TENTH_MUL_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WRITE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/trm_divider.sv @@
// Bit-serial restoring divider producing one quotient bit per cycle.
`default_nettype none

module trm_divider (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [trm_pkg::DIV_W-1:0]   dividend,
  input  wire logic [trm_pkg::CNT_W-1:0]   divisor,
  output logic                             done,
  output logic [trm_pkg::DIV_W-1:0]        quotient
);
  import trm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dvs;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;
  logic                 qbit;

  assign trial = {rem, quotient[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = (trial >= {1'b0, dvs});
  assign done  = busy && (count == DIV_CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      count <= count - DIV_CNT_W'(1);
      if (count == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quotient <= {quotient[DIV_W-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/traffic_rate_meter.sv @@
// Top level of the traffic rate meter: interval counters, running sums, peaks and averages.
//
// A packet transfer (req_type 0) adds its length and one packet to the interval counts,
// so packets may arrive on every cycle while the block is idle. A tick transfer
// (req_type 1) folds the interval counts into the running sums, updates the peaks and
// starts two bit-serial dividers for the averages; the block then holds in_stall high
// while the dividers run, and further while the previous result still waits in the
// output register. Each tick yields one result; packets yield none.
// interval_limit is written through cfg_wr_en and cfg_wr_data and resets to 60.
`default_nettype none

module traffic_rate_meter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [trm_pkg::LIMIT_W-1:0]     cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            req_type,
  input  wire logic [15:0]                     pkt_len,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [trm_pkg::OUT_BYTES_W-1:0]      interval_bytes,
  output logic [trm_pkg::OUT_PKTS_W-1:0]       interval_packets,
  output logic                                 avg_valid,
  output logic [trm_pkg::OUT_BYTES_W-1:0]      avg_bytes,
  output logic [trm_pkg::OUT_PKTS_W-1:0]       avg_packets,
  output logic [trm_pkg::OUT_BYTES_W-1:0]      peak_bytes,
  output logic [trm_pkg::OUT_PKTS_W-1:0]       peak_packets
);
  import trm_pkg::*;

  localparam int BW = BYTE_COUNT_WIDTH;

  state_t state;
  state_t state_next;

  logic [LIMIT_W-1:0]   interval_limit;
  logic [TENTH_W-1:0]   limit_tenth;
  logic [TENTH_PROD_W-1:0] tenth_prod;

  logic [BW-1:0]        byte_acc;
  logic [PKT_ACC_W-1:0] pkt_acc;
  logic [SUM_W-1:0]     byte_sum;
  logic [PKT_SUM_W-1:0] pkt_sum;
  logic [CNT_W-1:0]     interval_count;
  logic [BW-1:0]        byte_peak;
  logic [PKT_ACC_W-1:0] pkt_peak;

  logic [BW:0]          byte_acc_add;
  logic [BW-1:0]        byte_acc_next;
  logic [PKT_ACC_W-1:0] pkt_acc_next;
  logic [SUM_W:0]       byte_sum_add;
  logic [SUM_W-1:0]     byte_sum_next;
  logic [PKT_SUM_W:0]   pkt_sum_add;
  logic [PKT_SUM_W-1:0] pkt_sum_next;
  logic [CNT_W-1:0]     count_next;
  logic [BW-1:0]        byte_peak_next;
  logic [PKT_ACC_W-1:0] pkt_peak_next;
  logic                 valid_next;
  logic                 halve;

  logic                 res_valid;
  logic [OUT_BYTES_W-1:0] res_bytes;
  logic [OUT_PKTS_W-1:0]  res_packets;
  logic [OUT_BYTES_W-1:0] res_peak_bytes;
  logic [OUT_PKTS_W-1:0]  res_peak_packets;

  logic                 pkt_take;
  logic                 tick_take;
  logic                 div_start;
  logic                 load_out;
  logic                 div_done;
  logic                 div_done_p;
  logic [DIV_W-1:0]     quo_bytes;
  logic [DIV_W-1:0]     quo_packets;
  logic [63:0]          quo_bytes_64;
  logic [63:0]          quo_packets_64;
  logic [63:0]          acc_bytes_64;
  logic [63:0]          peak_bytes_64;

  trm_divider u_div_bytes (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_W'(byte_sum_next)),
    .divisor  (count_next),
    .done     (div_done),
    .quotient (quo_bytes)
  );

  trm_divider u_div_packets (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (DIV_W'(pkt_sum_next)),
    .divisor  (count_next),
    .done     (div_done_p),
    .quotient (quo_packets)
  );

  assign tenth_prod = TENTH_PROD_W'(cfg_wr_data) * TENTH_PROD_W'(TENTH_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_limit <= LIMIT_W'(LIMIT_RESET);
      limit_tenth    <= TENTH_W'(LIMIT_RESET / VALID_DIVISOR);
    end else if (cfg_wr_en) begin
      interval_limit <= cfg_wr_data;
      limit_tenth    <= TENTH_W'(tenth_prod >> TENTH_SHIFT);
    end
  end

  always_comb begin
    byte_acc_add   = {1'b0, byte_acc} + (BW + 1)'(pkt_len);
    byte_acc_next  = byte_acc_add[BW] ? '1 : byte_acc_add[BW-1:0];
    pkt_acc_next   = (&pkt_acc) ? pkt_acc : pkt_acc + PKT_ACC_W'(1);
    byte_sum_add   = {1'b0, byte_sum} + (SUM_W + 1)'(byte_acc);
    byte_sum_next  = byte_sum_add[SUM_W] ? '1 : byte_sum_add[SUM_W-1:0];
    pkt_sum_add    = {1'b0, pkt_sum} + (PKT_SUM_W + 1)'(pkt_acc);
    pkt_sum_next   = pkt_sum_add[PKT_SUM_W] ? '1 : pkt_sum_add[PKT_SUM_W-1:0];
    count_next     = (&interval_count) ? interval_count : interval_count + CNT_W'(1);
    byte_peak_next = (byte_acc > byte_peak) ? byte_acc : byte_peak;
    pkt_peak_next  = (pkt_acc > pkt_peak) ? pkt_acc : pkt_peak;
    valid_next     = count_next > CNT_W'(limit_tenth);
    halve          = count_next > CNT_W'(interval_limit);
  end

  always_comb begin
    acc_bytes_64   = 64'(byte_acc);
    peak_bytes_64  = 64'(byte_peak_next);
    quo_bytes_64   = 64'(quo_bytes);
    quo_packets_64 = 64'(quo_packets);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick_take) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_DIVIDE: in_stall = 1'b1;
      ST_WRITE:  load_out = !out_valid || !out_stall;
      default:   in_stall = 1'b1;
    endcase
  end

  assign pkt_take  = in_valid && !in_stall && !req_type;
  assign tick_take = in_valid && !in_stall && req_type;
  assign div_start = tick_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_acc       <= '0;
      pkt_acc        <= '0;
      byte_sum       <= '0;
      pkt_sum        <= '0;
      interval_count <= '0;
      byte_peak      <= '0;
      pkt_peak       <= '0;
    end else if (pkt_take) begin
      byte_acc <= byte_acc_next;
      pkt_acc  <= pkt_acc_next;
    end else if (tick_take) begin
      byte_acc       <= '0;
      pkt_acc        <= '0;
      byte_peak      <= byte_peak_next;
      pkt_peak       <= pkt_peak_next;
      byte_sum       <= halve ? (byte_sum_next >> 1) : byte_sum_next;
      pkt_sum        <= halve ? (pkt_sum_next >> 1) : pkt_sum_next;
      interval_count <= halve ? (count_next >> 1) : count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_take) begin
      res_valid        <= valid_next;
      res_bytes        <= (|acc_bytes_64[63:OUT_BYTES_W]) ? '1 : acc_bytes_64[OUT_BYTES_W-1:0];
      res_packets      <= pkt_acc;
      res_peak_bytes   <= (|peak_bytes_64[63:OUT_BYTES_W]) ? '1
                                                            : peak_bytes_64[OUT_BYTES_W-1:0];
      res_peak_packets <= pkt_peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      interval_bytes   <= res_bytes;
      interval_packets <= res_packets;
      avg_valid        <= res_valid;
      peak_bytes       <= res_peak_bytes;
      peak_packets     <= res_peak_packets;
      if (!res_valid) begin
        avg_bytes   <= '0;
        avg_packets <= '0;
      end else begin
        avg_bytes   <= (|quo_bytes_64[63:OUT_BYTES_W]) ? '1
                                                        : quo_bytes_64[OUT_BYTES_W-1:0];
        avg_packets <= (|quo_packets_64[63:OUT_PKTS_W]) ? '1
                                                         : quo_packets_64[OUT_PKTS_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_tick_clears_counts: assert property (@(posedge clk) disable iff (rst)
    tick_take |=> (byte_acc == '0) && (pkt_acc == '0))
    else $error("interval counts not cleared after a tick");

  a_tick_starts_divide: assert property (@(posedge clk) disable iff (rst)
    tick_take |=> state == ST_DIVIDE)
    else $error("tick did not start the divide phase");

  a_dividers_in_step: assert property (@(posedge clk) disable iff (rst)
    div_done == div_done_p)
    else $error("dividers finished in different cycles");

  a_result_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_WRITE)
    else $error("result presented outside the write phase");

  a_avg_zero_when_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !avg_valid |-> (avg_bytes == '0) && (avg_packets == '0))
    else $error("averages nonzero while not valid");
`endif

endmodule

`default_nettype wire
